// ===== hdl/wilson_hex_record_parser_unit_assert.svh =====
// ----------------------------------------------------------------------------
// wilson hex record parser assertion macros
// shared concurrent assertion forms for the parser rtl
// ----------------------------------------------------------------------------
`ifndef WILSON_HEX_RECORD_PARSER_UNIT_ASSERT_SVH
`define WILSON_HEX_RECORD_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define WHRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("whrp assertion failed");

// next-cycle implication
`define WHRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("whrp assertion failed");

`endif

// ===== hdl/whrp_pkg.sv =====
// ----------------------------------------------------------------------------
// whrp_pkg
// shared constants, codes and types of the wilson hex record parser
// ----------------------------------------------------------------------------
package whrp_pkg;

  localparam int unsigned ADDR_BYTES = 4;
  localparam int unsigned MAX_LINE   = 256;

  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_QUOTE = 8'h27;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] DIRECT_LO  = 8'h40;
  localparam logic [7:0] DIRECT_HI  = 8'hE0;
  localparam logic [7:0] PREFIX_LO  = 8'h3A;
  localparam logic [7:0] PREFIX_HI  = 8'h3E;
  localparam logic [7:0] NIB_LO     = 8'h30;
  localparam logic [7:0] SUM_GOOD   = 8'hFF;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_REC_END = 2'd1,
    KIND_EOI     = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ILLEGAL   = 3'd1,
    ST_BAD_LEN   = 3'd2,
    ST_CHECKSUM  = 3'd3,
    ST_NO_EOL    = 3'd4,
    ST_TOO_SHORT = 3'd5,
    ST_NO_DATA   = 3'd6
  } status_t;

  localparam int unsigned WARN_GARBAGE      = 0;
  localparam int unsigned WARN_TERM_NOT_END = 1;
  localparam int unsigned WARN_TERM_REDUND  = 2;
  localparam int unsigned WARN_EMPTY_DATA   = 3;
  localparam int unsigned WARN_TERM_DATA    = 4;
  localparam int unsigned WARN_NO_TERM      = 5;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } whrp_item_t;

  typedef struct packed {
    logic       is_hash;
    logic       is_quote;
    logic       is_nl;
    logic       is_direct;
    logic [7:0] direct_byte;
    logic       is_prefix;
    logic [3:0] prefix_nib;
    logic       is_nib;
    logic [7:0] nib_byte;
  } whrp_dec_t;

endpackage

// ===== hdl/whrp_if.sv =====
// ----------------------------------------------------------------------------
// whrp channel interfaces
// valid/ready channels for characters, results and configuration
// ----------------------------------------------------------------------------
interface whrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_input;

  modport source (output valid, output char_in, output end_of_input, input ready);
  modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

interface whrp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] address;
  logic [7:0]  data_byte;
  logic        record_type;
  logic [2:0]  status;
  logic [7:0]  sum_seen;
  logic [5:0]  warn_flags;

  modport source (output valid, output kind, output address, output data_byte,
                  output record_type, output status, output sum_seen,
                  output warn_flags, input ready);
  modport sink   (input valid, input kind, input address, input data_byte,
                  input record_type, input status, input sum_seen,
                  input warn_flags, output ready);
endinterface

interface whrp_cfg_if;
  logic valid;
  logic ready;
  logic check_enable;

  modport source (output valid, output check_enable, input ready);
  modport sink   (input valid, input check_enable, output ready);
endinterface

// ===== hdl/whrp_char_decode.sv =====
// ----------------------------------------------------------------------------
// whrp_char_decode
// classifies one character and forms its decoded byte values
// ----------------------------------------------------------------------------
module whrp_char_decode
  import whrp_pkg::*;
(
  input  logic [7:0] char_in,
  input  logic [3:0] high_nibble,
  output whrp_dec_t  dec
);

  always_comb begin
    dec.is_hash     = (char_in == CHAR_HASH);
    dec.is_quote    = (char_in == CHAR_QUOTE);
    dec.is_nl       = (char_in == CHAR_NL);
    dec.is_direct   = (char_in >= DIRECT_LO);
    dec.direct_byte = (char_in >= DIRECT_HI) ? char_in : (char_in - DIRECT_LO);
    dec.is_prefix   = (char_in >= PREFIX_LO) && (char_in < PREFIX_HI);
    dec.prefix_nib  = 4'(char_in - NIB_LO);
    dec.is_nib      = (char_in >= NIB_LO) && (char_in < DIRECT_LO);
    dec.nib_byte    = {high_nibble, char_in[3:0]};
  end

endmodule

// ===== hdl/whrp_core.sv =====
// ----------------------------------------------------------------------------
// whrp_core
// record state machine, byte handling and result register
// ----------------------------------------------------------------------------
`include "wilson_hex_record_parser_unit_assert.svh"

module whrp_core
  import whrp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          check_enable,
  input  logic          item_valid,
  input  whrp_item_t    item,
  output logic          item_taken,
  whrp_out_if.source    out_if
);

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_SKIP = 5'b00010,
    PH_BYTE = 5'b00100,
    PH_NIB  = 5'b01000,
    PH_EOL  = 5'b10000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  high_nibble_r, high_nibble_nxt;
  logic [7:0]  byte_index_r, byte_index_nxt;
  logic [7:0]  line_len_r, line_len_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic [31:0] record_addr_r, record_addr_nxt;
  logic        is_term_r, is_term_nxt;
  logic        garbage_warned_r, garbage_warned_nxt;
  logic        garbage_pending_r, garbage_pending_nxt;
  logic        any_seen_r, any_seen_nxt;
  logic        term_seen_r, term_seen_nxt;
  logic        halted_r, halted_nxt;

  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [31:0] out_address_r;
  logic [7:0]  out_data_r;
  logic        out_type_r;
  status_t     out_status_r;
  logic [7:0]  out_sum_r;
  logic [5:0]  out_warn_r;

  whrp_dec_t   dec;
  logic        out_free;
  logic        emit;
  logic        fail;
  kind_t       res_kind;
  logic [31:0] res_address;
  logic [7:0]  res_data;
  logic        res_type;
  status_t     res_status;
  logic [7:0]  res_sum;
  logic [5:0]  res_warn;
  logic        take;
  logic [7:0]  take_byte;
  logic [7:0]  sum_new;
  logic [7:0]  off;

  logic        out_is_data;
  logic        out_is_clean;
  logic        in_record_body;
  logic        out_is_bad_sum;

  whrp_char_decode u_dec (
    .char_in     (item.char_in),
    .high_nibble (high_nibble_r),
    .dec         (dec)
  );

  assign out_free   = !out_valid_r || out_if.ready;
  assign item_taken = item_valid && out_free;

  assign sum_new = running_sum_r + take_byte;
  assign off     = byte_index_r - 8'(ADDR_BYTES + 1);

  always_comb begin
    phase_nxt           = phase_r;
    high_nibble_nxt     = high_nibble_r;
    byte_index_nxt      = byte_index_r;
    line_len_nxt        = line_len_r;
    running_sum_nxt     = running_sum_r;
    record_addr_nxt     = record_addr_r;
    is_term_nxt         = is_term_r;
    garbage_warned_nxt  = garbage_warned_r;
    garbage_pending_nxt = garbage_pending_r;
    any_seen_nxt        = any_seen_r;
    term_seen_nxt       = term_seen_r;
    halted_nxt          = halted_r;
    emit                = 1'b0;
    fail                = 1'b0;
    res_kind            = KIND_REC_END;
    res_address         = record_addr_r;
    res_data            = '0;
    res_type            = is_term_r;
    res_status          = ST_OK;
    res_sum             = '0;
    res_warn            = '0;
    take                = 1'b0;
    take_byte           = dec.direct_byte;

    if (!halted_r) begin
      unique case (phase_r) inside
        PH_IDLE, PH_SKIP: begin
          if (item.end_of_input) begin
            if (!any_seen_r) begin
              fail       = 1'b1;
              res_kind   = KIND_EOI;
              res_status = ST_NO_DATA;
            end else begin
              emit                     = 1'b1;
              res_kind                 = KIND_EOI;
              res_address              = '0;
              res_type                 = 1'b0;
              res_warn[WARN_GARBAGE]   = garbage_pending_r;
              garbage_pending_nxt      = 1'b0;
              res_warn[WARN_NO_TERM]   = !term_seen_r;
              term_seen_nxt            = 1'b1;
              phase_nxt                = PH_IDLE;
            end
          end else if (phase_r == PH_SKIP) begin
            if (dec.is_nl) begin
              phase_nxt = PH_IDLE;
            end
          end else if (dec.is_hash || dec.is_quote) begin
            is_term_nxt     = dec.is_quote;
            running_sum_nxt = '0;
            byte_index_nxt  = '0;
            line_len_nxt    = '0;
            record_addr_nxt = '0;
            high_nibble_nxt = '0;
            phase_nxt       = PH_BYTE;
          end else if (!dec.is_nl) begin
            if (!garbage_warned_r) begin
              garbage_warned_nxt  = 1'b1;
              garbage_pending_nxt = 1'b1;
            end
            phase_nxt = PH_SKIP;
          end
        end
        PH_BYTE: begin
          if (item.end_of_input) begin
            fail       = 1'b1;
            res_status = ST_ILLEGAL;
          end else if (dec.is_direct) begin
            take = 1'b1;
          end else if (dec.is_prefix) begin
            high_nibble_nxt = dec.prefix_nib;
            phase_nxt       = PH_NIB;
          end else begin
            fail       = 1'b1;
            res_status = ST_ILLEGAL;
          end
        end
        PH_NIB: begin
          take_byte = dec.nib_byte;
          if (item.end_of_input || !dec.is_nib) begin
            fail       = 1'b1;
            res_status = ST_ILLEGAL;
          end else begin
            take = 1'b1;
          end
        end
        PH_EOL: begin
          if (item.end_of_input || !dec.is_nl) begin
            fail       = 1'b1;
            res_status = ST_NO_EOL;
          end else if ((line_len_r - 8'd1) < 8'(ADDR_BYTES)) begin
            fail       = 1'b1;
            res_status = ST_TOO_SHORT;
          end else begin
            emit                   = 1'b1;
            res_warn[WARN_GARBAGE] = garbage_pending_r;
            garbage_pending_nxt    = 1'b0;
            any_seen_nxt           = 1'b1;
            phase_nxt              = PH_IDLE;
            if (!is_term_r) begin
              if (term_seen_r) begin
                res_warn[WARN_TERM_NOT_END] = 1'b1;
                term_seen_nxt               = 1'b0;
              end
              res_warn[WARN_EMPTY_DATA] = (line_len_r == 8'(ADDR_BYTES + 1));
            end else begin
              res_warn[WARN_TERM_DATA]   = (line_len_r != 8'(ADDR_BYTES + 1));
              res_warn[WARN_TERM_REDUND] = term_seen_r;
              term_seen_nxt              = 1'b1;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase

      if (take) begin
        running_sum_nxt = sum_new;
        phase_nxt       = PH_BYTE;
        if (byte_index_r == '0) begin
          line_len_nxt = take_byte;
          if ((take_byte == '0) || ({1'b0, take_byte} > 9'(MAX_LINE))) begin
            fail       = 1'b1;
            res_status = ST_BAD_LEN;
          end else begin
            byte_index_nxt = 8'd1;
          end
        end else if (byte_index_r == line_len_r) begin
          if (check_enable && (sum_new != SUM_GOOD)) begin
            fail       = 1'b1;
            res_status = ST_CHECKSUM;
            res_sum    = sum_new;
          end else begin
            phase_nxt = PH_EOL;
          end
        end else begin
          byte_index_nxt = byte_index_r + 8'd1;
          if (byte_index_r <= 8'(ADDR_BYTES)) begin
            record_addr_nxt = {record_addr_r[23:0], take_byte};
          end else if (!is_term_r) begin
            emit        = 1'b1;
            res_kind    = KIND_DATA;
            res_address = record_addr_r + 32'(off);
            res_data    = take_byte;
            res_type    = 1'b0;
          end
        end
      end

      if (fail) begin
        emit                   = 1'b1;
        halted_nxt             = 1'b1;
        res_warn               = '0;
        res_warn[WARN_GARBAGE] = garbage_pending_r;
        garbage_pending_nxt    = 1'b0;
        if (res_kind == KIND_EOI) begin
          res_address = '0;
          res_type    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_IDLE;
      high_nibble_r     <= '0;
      byte_index_r      <= '0;
      line_len_r        <= '0;
      running_sum_r     <= '0;
      record_addr_r     <= '0;
      is_term_r         <= 1'b0;
      garbage_warned_r  <= 1'b0;
      garbage_pending_r <= 1'b0;
      any_seen_r        <= 1'b0;
      term_seen_r       <= 1'b0;
      halted_r          <= 1'b0;
    end else if (item_taken) begin
      phase_r           <= phase_nxt;
      high_nibble_r     <= high_nibble_nxt;
      byte_index_r      <= byte_index_nxt;
      line_len_r        <= line_len_nxt;
      running_sum_r     <= running_sum_nxt;
      record_addr_r     <= record_addr_nxt;
      is_term_r         <= is_term_nxt;
      garbage_warned_r  <= garbage_warned_nxt;
      garbage_pending_r <= garbage_pending_nxt;
      any_seen_r        <= any_seen_nxt;
      term_seen_r       <= term_seen_nxt;
      halted_r          <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_taken && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_taken && emit) begin
      out_kind_r    <= res_kind;
      out_address_r <= res_address;
      out_data_r    <= res_data;
      out_type_r    <= res_type;
      out_status_r  <= res_status;
      out_sum_r     <= res_sum;
      out_warn_r    <= res_warn;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.kind        = out_kind_r;
  assign out_if.address     = out_address_r;
  assign out_if.data_byte   = out_data_r;
  assign out_if.record_type = out_type_r;
  assign out_if.status      = out_status_r;
  assign out_if.sum_seen    = out_sum_r;
  assign out_if.warn_flags  = out_warn_r;

  assign out_is_data    = out_valid_r && (out_kind_r == KIND_DATA);
  assign out_is_clean   = (out_status_r == ST_OK) && (out_warn_r == '0);
  assign in_record_body = ((phase_r == PH_BYTE) || (phase_r == PH_NIB)) && (byte_index_r != '0);
  assign out_is_bad_sum = out_valid_r && (out_status_r == ST_CHECKSUM);

  // a fatal error holds until reset
  `WHRP_ASSERT_NEXT(a_halt_sticky, clk, rst_n, halted_r, halted_r)
  `WHRP_ASSERT_NOW(a_no_emit_halted, clk, rst_n, halted_r, !emit)
  `WHRP_ASSERT_NOW(a_data_clean, clk, rst_n, out_is_data, out_is_clean)
  `WHRP_ASSERT_NOW(a_index_bound, clk, rst_n, in_record_body, byte_index_r <= line_len_r)
  `WHRP_ASSERT_NOW(a_bad_sum, clk, rst_n, out_is_bad_sum, out_sum_r != SUM_GOOD)

endmodule

// ===== hdl/wilson_hex_record_parser_unit.sv =====
// ----------------------------------------------------------------------------
// wilson_hex_record_parser_unit
// parses a stream of wilson hex characters into data bytes and record results
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  in_if     in   valid/ready   char_in[7:0], end_of_input
//  out_if    out  valid/ready   kind, address, data_byte, record_type,
//                               status, sum_seen, warn_flags
//  cfg_if    in   valid/ready   check_enable
//
//  one character per cycle sustained while out_if.ready stays high
//  input register, combinational decode and record logic, result register
//  a stalled result holds while one more character waits in the input register
//  rst_n synchronous active low; check_enable resets to 1
//  after a fatal error characters are taken and dropped until reset
// ----------------------------------------------------------------------------
module wilson_hex_record_parser_unit
  import whrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  whrp_in_if.sink    in_if,
  whrp_out_if.source out_if,
  whrp_cfg_if.sink   cfg_if
);

  logic       s1_valid_r;
  whrp_item_t s1_item_r;
  logic       check_enable_r;
  logic       item_taken;

  assign in_if.ready  = !s1_valid_r || item_taken;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      s1_valid_r <= 1'b1;
    end else if (item_taken) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_item_r.char_in      <= in_if.char_in;
      s1_item_r.end_of_input <= in_if.end_of_input;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_enable_r <= 1'b1;
    end else if (cfg_if.valid && cfg_if.ready) begin
      check_enable_r <= cfg_if.check_enable;
    end
  end

  whrp_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .check_enable (check_enable_r),
    .item_valid   (s1_valid_r),
    .item         (s1_item_r),
    .item_taken   (item_taken),
    .out_if       (out_if)
  );

endmodule

// ===== tb/sv/wilson_hex_record_parser_unit_test.sv =====
// ----------------------------------------------------------------------------
// wilson_hex_record_parser_unit_test
// drives wilson hex text through the parser one character per transaction:
// a short directed file, then random records, garbage lines and end-of-input
// marks under all checksum settings, ending in one randomly chosen fatal
// error. a built-in line parser predicts every data byte, record end and
// end-of-input result, which are checked in order field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wilson_hex_record_parser_unit_test;
  import whrp_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 8;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SEGMENT_CHARS  = 150;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_SKIP,
    SCAN_BYTE,
    SCAN_NIBBLE,
    SCAN_NEWLINE
  } scan_phase_t;

  typedef enum int {
    END_BAD_CHAR,
    END_BAD_NIBBLE,
    END_EOI_BYTE,
    END_EOI_NIBBLE,
    END_ZERO_LEN,
    END_BAD_SUM,
    END_NO_NEWLINE,
    END_TOO_SHORT
  } ending_t;

  typedef struct {
    kind_t       kind;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic        record_type;
    status_t     status;
    logic [7:0]  sum_seen;
    logic [5:0]  warn_flags;
  } parse_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  whrp_in_if  in_if ();
  whrp_out_if out_if ();
  whrp_cfg_if cfg_if ();

  wilson_hex_record_parser_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  whrp_item_t    pending_chars[$];
  parse_result_t expected_results[$];
  int            queued_count = 0;
  int            mismatches   = 0;
  int            quiet_cycles = 0;
  bit            in_fire, out_fire, cfg_fire;
  int            in_gap, out_hold, in_calm, out_calm;

  // parser shadow state
  scan_phase_t scan_phase    = SCAN_IDLE;
  logic [3:0]  nibble_hi     = '0;
  logic [7:0]  byte_pos      = '0;
  logic [7:0]  rec_len       = '0;
  logic [7:0]  byte_sum      = '0;
  logic [31:0] rec_addr      = '0;
  logic        in_term_rec   = 1'b0;
  logic        garbage_noted = 1'b0;
  logic        garbage_owed  = 1'b0;
  logic        saw_record    = 1'b0;
  logic        saw_term      = 1'b0;
  logic        parser_dead   = 1'b0;
  logic        sum_check_on  = 1'b1;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic void post_result(kind_t kind, logic [31:0] address, logic [7:0] data_byte,
                                      logic record_type, status_t status, logic [7:0] sum_seen,
                                      logic [5:0] warn_flags);
    parse_result_t r;
    r.kind        = kind;
    r.address     = address;
    r.data_byte   = data_byte;
    r.record_type = record_type;
    r.status      = status;
    r.sum_seen    = sum_seen;
    r.warn_flags  = warn_flags;
    expected_results.push_back(r);
  endfunction

  function automatic logic [5:0] claim_garbage();
    logic [5:0] flags;
    flags = '0;
    flags[WARN_GARBAGE] = garbage_owed;
    garbage_owed = 1'b0;
    return flags;
  endfunction

  function automatic void post_fatal(kind_t kind, status_t status, logic [7:0] sum_seen);
    parser_dead = 1'b1;
    post_result(kind, (kind == KIND_REC_END) ? rec_addr : 32'd0, 8'd0,
                (kind == KIND_REC_END) && in_term_rec, status, sum_seen, claim_garbage());
  endfunction

  function automatic void take_record_byte(logic [7:0] b);
    logic [7:0] pos;
    pos = byte_pos;
    byte_sum = byte_sum + b;
    scan_phase = SCAN_BYTE;
    if (pos == 8'd0) begin
      rec_len = b;
      if (b == 8'd0 || int'(b) > MAX_LINE) begin
        post_fatal(KIND_REC_END, ST_BAD_LEN, 8'd0);
        return;
      end
      byte_pos = 8'd1;
      return;
    end
    if (pos == rec_len) begin
      if (sum_check_on && byte_sum != SUM_GOOD) begin
        post_fatal(KIND_REC_END, ST_CHECKSUM, byte_sum);
        return;
      end
      scan_phase = SCAN_NEWLINE;
      return;
    end
    byte_pos = pos + 8'd1;
    if (pos <= ADDR_BYTES) begin
      rec_addr = {rec_addr[23:0], b};
      return;
    end
    if (in_term_rec) return;
    post_result(KIND_DATA, rec_addr + 32'(int'(pos) - 1 - int'(ADDR_BYTES)), b, 1'b0, ST_OK,
                8'd0, 6'd0);
  endfunction

  function automatic void close_record();
    int         data_len;
    logic [5:0] flags;
    if (int'(rec_len) - 1 < int'(ADDR_BYTES)) begin
      post_fatal(KIND_REC_END, ST_TOO_SHORT, 8'd0);
      return;
    end
    data_len = int'(rec_len) - 1 - int'(ADDR_BYTES);
    flags = claim_garbage();
    saw_record = 1'b1;
    scan_phase = SCAN_IDLE;
    if (!in_term_rec) begin
      if (saw_term) begin
        flags[WARN_TERM_NOT_END] = 1'b1;
        saw_term = 1'b0;
      end
      if (data_len == 0) flags[WARN_EMPTY_DATA] = 1'b1;
    end else begin
      if (data_len > 0) flags[WARN_TERM_DATA] = 1'b1;
      if (saw_term) flags[WARN_TERM_REDUND] = 1'b1;
      saw_term = 1'b1;
    end
    post_result(KIND_REC_END, rec_addr, 8'd0, in_term_rec, ST_OK, 8'd0, flags);
  endfunction

  function automatic void scan_char(whrp_item_t item);
    logic [7:0] c;
    logic [5:0] flags;
    c = item.char_in;
    if (parser_dead) return;
    case (scan_phase)
      SCAN_IDLE, SCAN_SKIP: begin
        if (item.end_of_input) begin
          if (!saw_record) begin
            post_fatal(KIND_EOI, ST_NO_DATA, 8'd0);
          end else begin
            flags = claim_garbage();
            if (!saw_term) begin
              flags[WARN_NO_TERM] = 1'b1;
              saw_term = 1'b1;
            end
            scan_phase = SCAN_IDLE;
            post_result(KIND_EOI, 32'd0, 8'd0, 1'b0, ST_OK, 8'd0, flags);
          end
        end else if (scan_phase == SCAN_SKIP) begin
          if (c == CHAR_NL) scan_phase = SCAN_IDLE;
        end else if (c == CHAR_HASH || c == CHAR_QUOTE) begin
          in_term_rec = (c == CHAR_QUOTE);
          byte_sum    = '0;
          byte_pos    = '0;
          rec_len     = '0;
          rec_addr    = '0;
          nibble_hi   = '0;
          scan_phase  = SCAN_BYTE;
        end else if (c != CHAR_NL) begin
          if (!garbage_noted) begin
            garbage_noted = 1'b1;
            garbage_owed  = 1'b1;
          end
          scan_phase = SCAN_SKIP;
        end
      end
      SCAN_BYTE: begin
        if (item.end_of_input) begin
          post_fatal(KIND_REC_END, ST_ILLEGAL, 8'd0);
        end else if (c >= DIRECT_LO && c < DIRECT_HI) begin
          take_record_byte(c - DIRECT_LO);
        end else if (c >= DIRECT_HI) begin
          take_record_byte(c);
        end else if (c >= PREFIX_LO && c < PREFIX_HI) begin
          nibble_hi  = 4'(c - NIB_LO);
          scan_phase = SCAN_NIBBLE;
        end else begin
          post_fatal(KIND_REC_END, ST_ILLEGAL, 8'd0);
        end
      end
      SCAN_NIBBLE: begin
        if (item.end_of_input || c < NIB_LO || c > NIB_LO + 8'd15)
          post_fatal(KIND_REC_END, ST_ILLEGAL, 8'd0);
        else
          take_record_byte({nibble_hi, 4'(c - NIB_LO)});
      end
      default: begin
        if (item.end_of_input || c != CHAR_NL)
          post_fatal(KIND_REC_END, ST_NO_EOL, 8'd0);
        else
          close_record();
      end
    endcase
  endfunction

  // stimulus building
  function automatic void queue_char(logic [7:0] c);
    pending_chars.push_back('{char_in: c, end_of_input: 1'b0});
    queued_count++;
  endfunction

  function automatic void queue_eoi();
    pending_chars.push_back('{char_in: 8'($urandom), end_of_input: 1'b1});
    queued_count++;
  endfunction

  function automatic void queue_byte(logic [7:0] b);
    if (b < 8'hA0) begin
      queue_char(b + DIRECT_LO);
    end else if (b >= DIRECT_HI) begin
      queue_char(b);
    end else begin
      queue_char(NIB_LO + 8'(b[7:4]));
      queue_char(NIB_LO + 8'(b[3:0]));
    end
  endfunction

  function automatic void make_record(ref logic [7:0] rec_bytes[$], input logic [31:0] addr,
                                      input int n);
    rec_bytes.delete();
    rec_bytes.push_back(8'(1 + ADDR_BYTES + n));
    for (int i = ADDR_BYTES - 1; i >= 0; i--) rec_bytes.push_back(addr[8*i +: 8]);
    repeat (n) rec_bytes.push_back(8'($urandom));
  endfunction

  function automatic void seal_record(ref logic [7:0] rec_bytes[$], input bit bad_sum);
    logic [7:0] s;
    s = '0;
    foreach (rec_bytes[i]) s = s + rec_bytes[i];
    s = SUM_GOOD - s;
    if (bad_sum) s = s + 8'($urandom_range(1, 255));
    rec_bytes.push_back(s);
  endfunction

  function automatic void queue_line(bit term, logic [7:0] rec_bytes[$]);
    queue_char(term ? CHAR_QUOTE : CHAR_HASH);
    foreach (rec_bytes[i]) queue_byte(rec_bytes[i]);
    queue_char(CHAR_NL);
  endfunction

  function automatic void queue_garbage_line();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CHAR_HASH || c == CHAR_QUOTE || c == CHAR_NL);
    queue_char(c);
    repeat ($urandom_range(0, 6)) begin
      do c = 8'($urandom); while (c == CHAR_NL);
      queue_char(c);
    end
    if ($urandom_range(0, 4) == 0) queue_eoi();
    else queue_char(CHAR_NL);
  endfunction

  function automatic void queue_random_lines(int target, bit sums_checked);
    int          start_count;
    int          pick;
    int          n;
    logic [31:0] addr;
    logic [7:0]  rec_bytes[$];
    start_count = queued_count;
    while (queued_count - start_count < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 74) begin
        if (pick >= 62) begin
          n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
        end else if ($urandom_range(0, 32) == 0) begin
          n = $urandom_range(0, 1) ? 250 : $urandom_range(100, 249);
        end else begin
          n = $urandom_range(0, 10);
        end
        case ($urandom_range(0, 9))
          0, 1:    addr = 32'hFFFF_FFFF - $urandom_range(0, 8);
          2:       addr = $urandom_range(0, 15);
          default: addr = $urandom;
        endcase
        make_record(rec_bytes, addr, n);
        seal_record(rec_bytes, !sums_checked && $urandom_range(0, 2) == 0);
        queue_line(pick >= 62, rec_bytes);
      end else if (pick < 82) begin
        queue_garbage_line();
      end else if (pick < 88) begin
        queue_char(CHAR_NL);
      end else begin
        queue_eoi();
      end
    end
  endfunction

  function automatic int pick_gap(ref int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r < 2) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 110) return 0;
    if (r < 180) return $urandom_range(1, 3);
    if (r < 196) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endfunction

  task automatic wait_idle();
    while (pending_chars.size() != 0 || in_if.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_check_enable(logic value);
    @(negedge clk);
    cfg_if.check_enable <= value;
    cfg_if.valid        <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    sum_check_on = value;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // character driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fire) begin
      if (in_gap > 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (pending_chars.size() > 0) begin
        whrp_item_t item;
        item = pending_chars.pop_front();
        in_if.char_in      <= item.char_in;
        in_if.end_of_input <= item.end_of_input;
        in_if.valid        <= 1'b1;
        in_gap = pick_gap(in_calm);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      out_hold = pick_gap(out_calm);
    end
  end

  // monitor, prediction and watchdog
  always @(posedge clk) begin
    parse_result_t want;
    in_fire  = rst_n && in_if.valid && in_if.ready;
    out_fire = rst_n && out_if.valid && out_if.ready;
    cfg_fire = rst_n && cfg_if.valid && cfg_if.ready;
    if (rst_n) begin
      if (in_fire) scan_char('{char_in: in_if.char_in, end_of_input: in_if.end_of_input});
      if (out_fire) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result mismatch, expected none, actual kind %0d addr %h data %h",
                   $time, out_if.kind, out_if.address, out_if.data_byte,
                   " type %0d status %0d sum %h flags %h", out_if.record_type,
                   out_if.status, out_if.sum_seen, out_if.warn_flags);
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, out_if.kind);
          check_field("address", want.address, out_if.address);
          check_field("data_byte", want.data_byte, out_if.data_byte);
          check_field("record_type", want.record_type, out_if.record_type);
          check_field("status", want.status, out_if.status);
          check_field("sum_seen", want.sum_seen, out_if.sum_seen);
          check_field("warn_flags", want.warn_flags, out_if.warn_flags);
        end
      end
      if (in_fire || out_fire || cfg_fire) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** wilson_hex_record_parser_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] rec_bytes[$];
    ending_t    ending;
    int         cut;
    logic [7:0] c;

    in_if.valid         = 1'b0;
    in_if.char_in       = '0;
    in_if.end_of_input  = 1'b0;
    out_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.check_enable = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_check_enable(1'b1);

    if ($urandom_range(0, 15) == 0) begin
      // end of input before any record
      queue_garbage_line();
      queue_char(CHAR_NL);
      queue_garbage_line();
      queue_eoi();
    end else begin
      // garbage, blank line, empty record, wrapping record, missing termination
      queue_char(8'h67);
      queue_char(CHAR_NL);
      queue_char(CHAR_NL);
      make_record(rec_bytes, 32'd0, 0);
      seal_record(rec_bytes, 1'b0);
      queue_line(1'b0, rec_bytes);
      make_record(rec_bytes, 32'hFFFF_FFFF, 0);
      rec_bytes[0] = 8'(1 + ADDR_BYTES + 4);
      rec_bytes.push_back(8'h00);
      rec_bytes.push_back(8'hAF);
      rec_bytes.push_back(8'hD0);
      rec_bytes.push_back(8'hFF);
      seal_record(rec_bytes, 1'b0);
      queue_line(1'b0, rec_bytes);
      queue_eoi();

      queue_random_lines(SEGMENT_CHARS, 1'b1);
      wait_idle();
      set_check_enable(1'b0);
      queue_random_lines(SEGMENT_CHARS, 1'b0);
      wait_idle();
      c = 8'($urandom_range(0, 1));
      set_check_enable(c[0]);
      queue_random_lines(SEGMENT_CHARS, c[0]);
      wait_idle();
      set_check_enable(1'b1);

      // one fatal error closes the file
      ending = ending_t'($urandom_range(0, 7));
      if (ending == END_TOO_SHORT) begin
        rec_bytes.delete();
        rec_bytes.push_back(8'($urandom_range(1, ADDR_BYTES)));
        repeat (rec_bytes[0] - 1) rec_bytes.push_back(8'($urandom));
        seal_record(rec_bytes, 1'b0);
      end else if (ending == END_ZERO_LEN) begin
        rec_bytes = '{8'd0};
      end else begin
        make_record(rec_bytes, $urandom, $urandom_range(0, 6));
        seal_record(rec_bytes, ending == END_BAD_SUM);
      end
      cut = $urandom_range(0, rec_bytes.size() - 1);
      queue_char($urandom_range(0, 1) ? CHAR_QUOTE : CHAR_HASH);
      case (ending)
        END_BAD_CHAR, END_BAD_NIBBLE, END_EOI_BYTE, END_EOI_NIBBLE: begin
          for (int i = 0; i < cut; i++) queue_byte(rec_bytes[i]);
          if (ending == END_BAD_NIBBLE || ending == END_EOI_NIBBLE)
            queue_char(8'($urandom_range(PREFIX_LO, PREFIX_HI - 1)));
          if (ending == END_BAD_CHAR) begin
            c = 8'($urandom_range(0, 8'h3B));
            if (c >= PREFIX_LO) c = c + 8'd4;
            queue_char(c);
          end else if (ending == END_BAD_NIBBLE) begin
            c = 8'($urandom_range(0, 239));
            if (c >= NIB_LO) c = c + 8'd16;
            queue_char(c);
          end else begin
            queue_eoi();
          end
        end
        END_NO_NEWLINE: begin
          foreach (rec_bytes[i]) queue_byte(rec_bytes[i]);
          if ($urandom_range(0, 2) == 0) begin
            queue_eoi();
          end else begin
            do c = 8'($urandom); while (c == CHAR_NL);
            if ($urandom_range(0, 1)) c = 8'h0D;
            queue_char(c);
          end
        end
        default: begin
          foreach (rec_bytes[i]) queue_byte(rec_bytes[i]);
          queue_char(CHAR_NL);
        end
      endcase
    end

    // anything after a fatal error is dropped
    repeat ($urandom_range(5, 20)) begin
      pending_chars.push_back('{char_in: 8'($urandom), end_of_input: 1'($urandom)});
      queued_count++;
    end

    wait_idle();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("** wilson_hex_record_parser_unit: PASSED **");
    end else begin
      $display("** wilson_hex_record_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule
